/* rtl/pssm_pkg.sv */
// Shared types, constants and helpers for the pinned snapshot slot manager.
package pssm_pkg;

   localparam int SLOTS      = 4;
   localparam int PIN_WIDTH  = 8;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int SLOT_OUT_W = 4;
   localparam int WORD_W     = 32;

   typedef logic [SLOT_W-1:0]    slot_idx_type;
   typedef logic [PIN_WIDTH-1:0] pin_type;
   typedef logic [WORD_W-1:0]    word_type;

   typedef enum logic [1:0] {
      KIND_PIN     = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_PUBLISH = 2'd2,
      KIND_READ    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      kind_type              kind;
      logic [SLOT_OUT_W-1:0] release_slot;
      word_type              new_revision;
      word_type              new_payload;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic [SLOT_OUT_W-1:0] slot;
      word_type              snapshot_id;
      word_type              revision;
      word_type              payload;
   } rsp_type;

   typedef struct packed {
      logic         done;
      logic         found;
      slot_idx_type pick;
   } scan_res_type;

   // Round-robin successor of a slot index.
   function automatic slot_idx_type next_slot(input slot_idx_type s);
      slot_idx_type r;
      if (s == SLOT_W'(SLOTS - 1)) begin
         r = '0;
      end else begin
         r = s + SLOT_W'(1);
      end
      return r;
   endfunction

endpackage

/* rtl/pssm_scan.sv */
// Round-robin free-slot search, one candidate slot per cycle.
module pssm_scan import pssm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  slot_idx_type     base,
   input  slot_idx_type     active,
   input  logic [SLOTS-1:0] free,
   output scan_res_type     res
);

   logic         busy_ff, busy_in;
   slot_idx_type cand_ff, cand_in;
   slot_idx_type left_ff, left_in;
   logic         hit;
   logic         last;

   assign hit  = busy_ff && (cand_ff != active) && free[cand_ff];
   assign last = (left_ff == '0);

   assign res.done  = busy_ff && (hit || last);
   assign res.found = hit;
   assign res.pick  = cand_ff;

   always_comb begin
      busy_in = busy_ff;
      cand_in = cand_ff;
      left_in = left_ff;
      if (start) begin
         busy_in = 1'b1;
         cand_in = next_slot(base);
         left_in = SLOT_W'(SLOTS - 1);
      end else if (busy_ff) begin
         if (hit || last) begin
            busy_in = 1'b0;
         end else begin
            cand_in = next_slot(cand_ff);
            left_in = left_ff - SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cand_ff <= cand_in;
      left_ff <= left_in;
   end

endmodule

/* rtl/pinned_snapshot_slot_manager_top.sv */
// Pin, release and read pass through EXEC and then offer their response in RESP.
// Publish passes through EXEC, then SCAN, where the search unit tests candidate slots one per cycle,
// then WRITE and RESP, or goes from SCAN straight to RESP when no slot is free; one item in flight at a time.
// A new request is taken only in IDLE, after the previous response has been accepted.
// Reset (synchronous, active high) clears all slots and pin counts, selects slot 0,
// and sets the next id to one.
module pinned_snapshot_slot_manager_top import pssm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type    state_ff, state_in;
   req_type      req_ff;
   word_type     rev_ff, rev_in;
   rsp_type      rsp_ff, rsp_in;
   pin_type      pin_ff [SLOTS];
   word_type     pay_ff [SLOTS];
   word_type     revs_ff [SLOTS];
   slot_idx_type active_ff;
   slot_idx_type last_ff;
   word_type     next_id_ff;
   word_type     active_id_ff;

   logic             accept;
   logic             scan_start;
   logic             load_rsp;
   logic             do_write;
   logic             do_pins;
   logic [SLOTS-1:0] free;
   scan_res_type     scan_res;
   word_type         cur_rev;
   rsp_type          active_rsp;

   assign accept  = req_valid && req_ready;
   assign cur_rev = revs_ff[active_ff];

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         free[i] = (pin_ff[i] == '0);
      end
   end

   pssm_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (scan_start),
      .base   (last_ff),
      .active (active_ff),
      .free   (free),
      .res    (scan_res)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (req_ff.kind == KIND_PUBLISH) state_in = ST_SCAN;
            else                             state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (scan_res.done) state_in = scan_res.found ? ST_WRITE : ST_RESP;
         end
         ST_WRITE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      scan_start = 1'b0;
      load_rsp   = 1'b0;
      do_write   = 1'b0;
      do_pins    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            if (req_ff.kind == KIND_PUBLISH) begin
               scan_start = 1'b1;
            end else begin
               do_pins  = 1'b1;
               load_rsp = 1'b1;
            end
         end
         ST_SCAN: begin
            load_rsp = scan_res.done && !scan_res.found;
         end
         ST_WRITE: begin
            do_write = 1'b1;
            load_rsp = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Forced revision: must end up above the active one, wrapping
   always_comb begin
      if (req_ff.new_revision <= cur_rev) rev_in = cur_rev + WORD_W'(1);
      else                                rev_in = req_ff.new_revision;
   end

   always_comb begin
      active_rsp.ok          = (state_ff != ST_SCAN);
      active_rsp.slot        = SLOT_OUT_W'(active_ff);
      active_rsp.snapshot_id = active_id_ff;
      active_rsp.revision    = cur_rev;
      active_rsp.payload     = pay_ff[active_ff];
      if (do_write) begin
         rsp_in.ok          = 1'b1;
         rsp_in.slot        = SLOT_OUT_W'(scan_res.pick);
         rsp_in.snapshot_id = next_id_ff;
         rsp_in.revision    = rev_ff;
         rsp_in.payload     = req_ff.new_payload;
      end else begin
         rsp_in = active_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         last_ff      <= '0;
         next_id_ff   <= WORD_W'(1);
         active_id_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            pin_ff[i]  <= '0;
            pay_ff[i]  <= '0;
            revs_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (do_pins) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (req_ff.kind == KIND_PIN && active_ff == SLOT_W'(i)
                   && pin_ff[i] != '1) begin
                  pin_ff[i] <= pin_ff[i] + PIN_WIDTH'(1);
               end else if (req_ff.kind == KIND_RELEASE
                            && (5'(req_ff.release_slot) < 5'(SLOTS))
                            && SLOT_W'(req_ff.release_slot) == SLOT_W'(i)
                            && pin_ff[i] != '0) begin
                  pin_ff[i] <= pin_ff[i] - PIN_WIDTH'(1);
               end
            end
         end
         if (do_write) begin
            pay_ff[scan_res.pick]  <= req_ff.new_payload;
            revs_ff[scan_res.pick] <= rev_ff;
            next_id_ff             <= next_id_ff + WORD_W'(1);
            last_ff                <= scan_res.pick;
            active_ff              <= scan_res.pick;
            active_id_ff           <= next_id_ff;
         end
      end
      if (accept) req_ff <= req_data;
      if (scan_start) rev_ff <= rev_in;
      if (load_rsp) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while an item is in flight");

   a_active_only_on_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_WRITE) |=> (active_ff == $past(active_ff)))
      else $error("active slot moved outside a publish write");

   a_id_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |=> (next_id_ff == $past(next_id_ff) + WORD_W'(1)))
      else $error("id counter did not step on publish");

   a_fail_keeps_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.slot == SLOT_OUT_W'(active_ff)))
      else $error("failed publish reports a slot other than the active one");

   a_pick_not_active: assert property (@(posedge clock) disable iff (reset)
      (scan_res.done && scan_res.found) |-> (scan_res.pick != active_ff && free[scan_res.pick]))
      else $error("scan picked the active or a pinned slot");

endmodule

/* tb/pinned_snapshot_slot_manager_top_test.sv */
// Self-checking testbench for the pinned snapshot slot manager: directed, saturation and random traffic.
`timescale 1ns / 100ps

module pinned_snapshot_slot_manager_top_test;
   import pssm_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 32;
   localparam int RANDOM_ITEMS  = 1260;
   localparam int HOLD_CYCLES   = 400;

   class snapshot_scoreboard;
      word_type     stored_payload[SLOTS];
      word_type     stored_revision[SLOTS];
      word_type     stored_id[SLOTS];
      pin_type      pin_depth[SLOTS];
      slot_idx_type live_slot;
      slot_idx_type last_fill;
      word_type     id_counter;
      word_type     live_id;
      rsp_type      expected_snapshots[$];
      int unsigned  mismatches;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            stored_payload[i]  = '0;
            stored_revision[i] = '0;
            stored_id[i]       = '0;
            pin_depth[i]       = '0;
         end
         live_slot  = '0;
         last_fill  = '0;
         id_counter = 32'd1;
         live_id    = '0;
         mismatches = 0;
      endfunction

      // Advances the shadow state by one item and returns the snapshot it should report.
      function rsp_type apply_request(req_type r);
         rsp_type      snap;
         logic         ok;
         logic         found;
         slot_idx_type pick;
         slot_idx_type rel;
         word_type     rev;
         int           c;
         ok = 1'b1;
         case (r.kind)
            KIND_PIN: begin
               if (pin_depth[live_slot] != '1) begin
                  pin_depth[live_slot] = pin_depth[live_slot] + PIN_WIDTH'(1);
               end
            end
            KIND_RELEASE: begin
               rel = slot_idx_type'(r.release_slot);
               if (r.release_slot < SLOTS && pin_depth[rel] != '0) begin
                  pin_depth[rel] = pin_depth[rel] - PIN_WIDTH'(1);
               end
            end
            KIND_PUBLISH: begin
               rev = r.new_revision;
               if (rev <= stored_revision[live_slot]) rev = stored_revision[live_slot] + 32'd1;
               found = 1'b0;
               pick  = '0;
               // round-robin from the slot after the last one written
               for (int i = 0; i < SLOTS; i++) begin
                  c = (int'(last_fill) + 1 + i) % SLOTS;
                  if (!found && slot_idx_type'(c) != live_slot
                      && pin_depth[slot_idx_type'(c)] == '0) begin
                     found = 1'b1;
                     pick  = slot_idx_type'(c);
                  end
               end
               if (found) begin
                  stored_payload[pick]  = r.new_payload;
                  stored_revision[pick] = rev;
                  stored_id[pick]       = id_counter;
                  id_counter            = id_counter + 32'd1;
                  last_fill             = pick;
                  live_id               = stored_id[pick];
                  live_slot             = pick;
               end else begin
                  ok = 1'b0;
               end
            end
            default: ;
         endcase
         snap.ok          = ok;
         snap.slot        = SLOT_OUT_W'(live_slot);
         snap.snapshot_id = live_id;
         snap.revision    = stored_revision[live_slot];
         snap.payload     = stored_payload[live_slot];
         return snap;
      endfunction

      function void note_request(req_type r);
         expected_snapshots.push_back(apply_request(r));
      endfunction

      function void compare_field(string field, word_type want, word_type got);
         if (want !== got) begin
            $error("field %s: expected %h, actual %h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_snapshots.size() == 0) begin
            $error("response transfer with nothing outstanding: %p", got);
            mismatches++;
         end else begin
            want = expected_snapshots.pop_front();
            compare_field("ok", word_type'(want.ok), word_type'(got.ok));
            compare_field("slot", word_type'(want.slot), word_type'(got.slot));
            compare_field("snapshot_id", want.snapshot_id, got.snapshot_id);
            compare_field("revision", want.revision, got.revision);
            compare_field("payload", want.payload, got.payload);
         end
      endfunction

      function int outstanding();
         return expected_snapshots.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   snapshot_scoreboard board;
   bit idling       = 1'b1;
   bit hold_request = 1'b0;

   pinned_snapshot_slot_manager_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic send_item(input req_type item);
      while (idling && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_request(item);
   endtask

   task automatic send_op(input kind_type k, input logic [SLOT_OUT_W-1:0] rel,
                          input word_type rev, input word_type pay);
      req_type item;
      item.kind         = k;
      item.release_slot = rel;
      item.new_revision = rev;
      item.new_payload  = pay;
      send_item(item);
   endtask

   task automatic run_directed();
      send_op(KIND_READ, '0, '0, '0);
      send_op(KIND_RELEASE, 4'd2, $urandom(), $urandom());     // unpinned slot
      send_op(KIND_RELEASE, 4'd15, $urandom(), $urandom());    // out of range
      send_op(KIND_RELEASE, 4'(SLOTS), $urandom(), $urandom());
      send_op(KIND_PIN, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(KIND_PUBLISH, 4'h0, 32'h0, 32'h0);               // revision raised
      send_op(KIND_PIN, 4'($urandom()), $urandom(), $urandom());
      send_op(KIND_PUBLISH, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(KIND_PIN, 4'($urandom()), $urandom(), $urandom());
      send_op(KIND_PUBLISH, 4'h0, 32'h0, 32'hA5A5_5A5A);       // revision wraps to zero
      send_op(KIND_PUBLISH, 4'($urandom()), $urandom(), $urandom()); // every other slot pinned
      send_op(KIND_READ, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(KIND_RELEASE, 4'd0, $urandom(), $urandom());
      send_op(KIND_RELEASE, 4'd1, $urandom(), $urandom());
      send_op(KIND_RELEASE, 4'd2, $urandom(), $urandom());
      send_op(KIND_RELEASE, 4'd0, $urandom(), $urandom());
      send_op(KIND_PUBLISH, 4'($urandom()), 32'd5, $urandom());
      send_op(KIND_PUBLISH, 4'($urandom()), 32'd5, $urandom());    // equal revision
      send_op(KIND_PUBLISH, 4'($urandom()), 32'd2, $urandom());    // lower revision
      send_op(KIND_READ, 4'($urandom()), $urandom(), $urandom());
   endtask

   // Drive one slot's pin count into saturation and back down to zero.
   task automatic run_saturation();
      int           depth;
      slot_idx_type pinned;
      depth  = (1 << PIN_WIDTH) + 4;
      pinned = board.live_slot;
      for (int i = 0; i < depth; i++) send_op(KIND_PIN, 4'($urandom()), $urandom(), $urandom());
      send_op(KIND_PUBLISH, 4'($urandom()), $urandom(), $urandom());
      for (int i = 0; i < depth; i++) begin
         send_op(KIND_RELEASE, SLOT_OUT_W'(pinned), $urandom(), $urandom());
      end
   endtask

   task automatic run_random();
      req_type  item;
      bit       pin_heavy;
      int       roll;
      word_type live_rev;
      pin_heavy = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) pin_heavy = ($urandom_range(2) == 0);
         idling = !(n >= 500 && n < 800);
         if (n == 1000) hold_request = 1'b1;
         item.release_slot = 4'($urandom_range(15));
         item.new_revision = $urandom();
         item.new_payload  = $urandom();
         roll = $urandom_range(99);
         if (roll < (pin_heavy ? 40 : 20)) begin
            item.kind = KIND_PIN;
         end else if (roll < (pin_heavy ? 50 : 45)) begin
            item.kind = KIND_RELEASE;
            if ($urandom_range(99) < 85) item.release_slot = 4'($urandom_range(SLOTS - 1));
         end else if (roll < (pin_heavy ? 90 : 80)) begin
            item.kind = KIND_PUBLISH;
            live_rev  = board.stored_revision[board.live_slot];
            case ($urandom_range(5))
               0: item.new_revision = live_rev;
               1: item.new_revision = live_rev - 32'd1;
               2: item.new_revision = live_rev + 32'($urandom_range(3));
               3: item.new_revision = '0;
               4: item.new_revision = 32'hFFFF_FFFF - 32'($urandom_range(3));
               default: ;
            endcase
         end else begin
            item.kind = KIND_READ;
         end
         send_item(item);
      end
      idling = 1'b1;
   endtask

   // Response side: checks each transfer and throttles rsp_ready.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) board.check_response(rsp_data);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (idling) begin
            rsp_ready <= ($urandom_range(99) >= 26);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("** pinned_snapshot_slot_manager_top: FAILED **");
      $finish;
   end

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_saturation();
      run_random();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("** pinned_snapshot_slot_manager_top: PASSED **");
      end else begin
         $display("** pinned_snapshot_slot_manager_top: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/pssm_pkg.sv
rtl/pssm_scan.sv
rtl/pinned_snapshot_slot_manager_top.sv
tb/pinned_snapshot_slot_manager_top_test.sv
